/* sv/lrk_pkg.sv */
// Shared types, constants and codes for the LRU-K frame replacer.
package lrk_pkg;

	localparam int MaxFramesDef  = 64;
	localparam int MaxHistoryDef = 15;

	localparam logic [1:0] KIND_ACCESS = 2'd0;
	localparam logic [1:0] KIND_MARK   = 2'd1;
	localparam logic [1:0] KIND_REMOVE = 2'd2;
	localparam logic [1:0] KIND_EVICT  = 2'd3;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_INVALID = 2'd1;
	localparam logic [1:0] ST_PINNED  = 2'd2;
	localparam logic [1:0] ST_EMPTY   = 2'd3;

	localparam logic [1:0] REG_FRAMES  = 2'd0;
	localparam logic [1:0] REG_HISTORY = 2'd1;

	// datapath command: what the controller asks of the datapath this cycle
	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_LOAD,       // latch item, read per-frame info
		CMD_SCAN_RD,    // issue list read at scan index
		CMD_SCAN_CHK,   // compare list data at scan index
		CMD_MARK_RD,    // read per-frame info of the list entry
		CMD_MARK_CHK,   // test evictable mark of the list entry
		CMD_SHIFT_RD,   // read entry idx+1
		CMD_SHIFT_WR,   // write entry idx with read data
		CMD_DROP_END,   // length minus one
		CMD_APPEND,     // write frame at tail, length plus one
		CMD_APPLY       // update count / mark / evictable total
	} cmd_t;

	typedef struct packed {
		cmd_t cmd;
		logic sel_old;   // list addressed: 0 young, 1 old
		logic idx_clr;   // clear scan index
	} ctl_t;

	typedef struct packed {
		logic hit;       // scan: entry matches (mark of entry, in pick mode)
		logic at_end;    // scan index reached list length
		logic shift_end; // idx+1 reached length
		logic [1:0] kind;
		logic invalid;
		logic tracked;
		logic marked;
		logic cnt_ge_k;  // count after increment reaches k
		logic k_is_one;
		logic any_evict;
		logic clearing;  // per-frame table being zeroed after reset
	} sts_t;

endpackage

/* sv/lrk_ram.sv */
// Generic single-port RAM with registered read.
module lrk_ram #(
	parameter int Width = 8,
	parameter int Depth = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] addr,
	input  logic [Width-1:0]         wdata,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) mem_q[addr] <= wdata;
		rdata <= mem_q[addr];
	end
endmodule

/* sv/lrk_datapath.sv */
// Datapath: per-frame state, list memories, scan index and lengths.
module lrk_datapath #(
	parameter int MaxFrames  = lrk_pkg::MaxFramesDef,
	parameter int MaxHistory = lrk_pkg::MaxHistoryDef
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  lrk_pkg::ctl_t                       ctl,
	input  logic                                pick_mode,
	input  logic [1:0]                          in_kind,
	input  logic [7:0]                          in_frame,
	input  logic                                in_mk,
	input  logic [6:0]                          frames_in_use,
	input  logic [3:0]                          history_depth,
	output lrk_pkg::sts_t                       sts,
	output logic [$clog2(MaxFrames)-1:0]        victim,
	output logic [$clog2(MaxFrames+1)-1:0]      ev_total
);
	import lrk_pkg::*;

	localparam int AW = $clog2(MaxFrames);
	localparam int LW = $clog2(MaxFrames + 1);
	localparam int CW = $clog2(MaxHistory + 1);
	localparam int IW = CW + 1;

	logic [LW-1:0] ylen_q, olen_q, evcnt_q, idx_q;
	logic [1:0]    kind_q;
	logic [AW-1:0] frame_q;
	logic          mk_q, invalid_q;
	logic [CW-1:0] k_q;
	logic [AW-1:0] victim_q;
	logic          clr_q;
	logic [AW-1:0] clr_idx_q;

	logic [LW-1:0] len;
	logic [LW-1:0] idx_nx;
	logic          we_y, we_o, we_i;
	logic [AW-1:0] addr;
	logic [AW-1:0] wdata, rd_y, rd_o, rd;
	logic [AW-1:0] iaddr;
	logic [IW-1:0] info_rd, info_wr;   // {mark, count}
	logic [CW-1:0] cnt_f;
	logic          mark_f;
	logic [CW-1:0] k_eff;
	logic [LW-1:0] limit;

	assign len    = ctl.sel_old ? olen_q : ylen_q;
	assign idx_nx = idx_q + LW'(1);
	assign rd     = ctl.sel_old ? rd_o : rd_y;
	assign cnt_f  = info_rd[CW-1:0];
	assign mark_f = info_rd[CW];

	always_comb begin
		addr  = idx_q[AW-1:0];
		wdata = frame_q;
		we_y  = 1'b0;
		we_o  = 1'b0;
		case (ctl.cmd)
			CMD_SHIFT_RD: addr = idx_nx[AW-1:0];
			CMD_SHIFT_WR: begin
				wdata = rd;
				we_y  = !ctl.sel_old;
				we_o  = ctl.sel_old;
			end
			CMD_APPEND: begin
				addr = len[AW-1:0];
				we_y = !ctl.sel_old && (len < LW'(MaxFrames));
				we_o = ctl.sel_old && (len < LW'(MaxFrames));
			end
			default: ;
		endcase
	end

	lrk_ram #(.Width(AW), .Depth(MaxFrames)) u_young (
		.clk(clk), .we(we_y), .addr(addr), .wdata(wdata), .rdata(rd_y));
	lrk_ram #(.Width(AW), .Depth(MaxFrames)) u_old (
		.clk(clk), .we(we_o), .addr(addr), .wdata(wdata), .rdata(rd_o));

	// per-frame info port: follows frame_q unless clearing, loading or reading the mark of a list entry
	always_comb begin
		iaddr   = frame_q;
		we_i    = 1'b0;
		info_wr = '0;
		if (clr_q) begin
			iaddr = clr_idx_q;
			we_i  = 1'b1;
		end else begin
			case (ctl.cmd)
				CMD_LOAD:    iaddr = in_frame[AW-1:0];
				CMD_MARK_RD: iaddr = rd;
				CMD_APPLY: begin
					we_i = 1'b1;
					case (kind_q)
						KIND_ACCESS: begin
							if (cnt_f == '0) info_wr = {mark_f, CW'(1)};
							else if (cnt_f < k_q) info_wr = {mark_f, cnt_f + CW'(1)};
							else info_wr = {mark_f, cnt_f};
						end
						KIND_MARK: info_wr = {(cnt_f != '0) ? mk_q : mark_f, cnt_f};
						default: info_wr = '0;
					endcase
				end
				default: ;
			endcase
		end
	end

	lrk_ram #(.Width(IW), .Depth(MaxFrames)) u_info (
		.clk(clk), .we(we_i), .addr(iaddr), .wdata(info_wr), .rdata(info_rd));

	always_comb begin
		k_eff = (history_depth == 4'd0) ? CW'(1) : CW'(history_depth);
		if (CW > 4 || MaxHistory < 15)
			if (32'(history_depth) > MaxHistory) k_eff = CW'(MaxHistory);
		limit = (32'(frames_in_use) < MaxFrames) ? LW'(frames_in_use) : LW'(MaxFrames);
	end

	always_ff @(posedge clk) begin
		if (ctl.cmd == CMD_LOAD) begin
			kind_q    <= in_kind;
			frame_q   <= in_frame[AW-1:0];
			mk_q      <= in_mk;
			invalid_q <= (in_kind != KIND_EVICT) &&
			             ({24'd0, in_frame} >= 32'(limit));
			k_q       <= k_eff;
		end else if (ctl.cmd == CMD_MARK_CHK && sts.hit) begin
			frame_q   <= rd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ylen_q    <= '0;
			olen_q    <= '0;
			evcnt_q   <= '0;
			idx_q     <= '0;
			victim_q  <= '0;
			clr_q     <= 1'b1;
			clr_idx_q <= '0;
		end else begin
			if (clr_q) begin
				clr_idx_q <= clr_idx_q + AW'(1);
				if (clr_idx_q == AW'(MaxFrames - 1)) clr_q <= 1'b0;
			end
			if (ctl.idx_clr) idx_q <= '0;
			else if ((ctl.cmd == CMD_SCAN_CHK || ctl.cmd == CMD_MARK_CHK) && !sts.hit)
				idx_q <= idx_nx;
			else if (ctl.cmd == CMD_SHIFT_WR) idx_q <= idx_nx;
			if (ctl.cmd == CMD_MARK_CHK && sts.hit) victim_q <= rd;
			if (ctl.cmd == CMD_LOAD) victim_q <= '0;
			if (ctl.cmd == CMD_DROP_END) begin
				if (ctl.sel_old) olen_q <= olen_q - LW'(1);
				else ylen_q <= ylen_q - LW'(1);
			end
			if (ctl.cmd == CMD_APPEND && len < LW'(MaxFrames)) begin
				if (ctl.sel_old) olen_q <= olen_q + LW'(1);
				else ylen_q <= ylen_q + LW'(1);
			end
			if (ctl.cmd == CMD_APPLY) begin
				case (kind_q)
					KIND_ACCESS: ;
					KIND_MARK: begin
						if (cnt_f != '0) begin
							if (mark_f && !mk_q) begin
								if (evcnt_q != '0) evcnt_q <= evcnt_q - LW'(1);
							end else if (!mark_f && mk_q) begin
								evcnt_q <= evcnt_q + LW'(1);
							end
						end
					end
					default: begin
						if (mark_f && evcnt_q != '0) evcnt_q <= evcnt_q - LW'(1);
					end
				endcase
			end
		end
	end

	always_comb begin
		sts.hit       = pick_mode ? mark_f : (rd == frame_q);
		sts.at_end    = (idx_q >= len);
		sts.shift_end = (idx_nx >= len);
		sts.kind      = kind_q;
		sts.invalid   = invalid_q;
		sts.tracked   = (cnt_f != '0);
		sts.marked    = mark_f;
		sts.cnt_ge_k  = ((cnt_f < k_q) ? cnt_f + CW'(1) : cnt_f) >= k_q;
		sts.k_is_one  = (k_q <= CW'(1));
		sts.any_evict = (evcnt_q != '0);
		sts.clearing  = clr_q;
	end

	assign victim   = victim_q;
	assign ev_total = evcnt_q;
endmodule

/* sv/lrk_ctrl.sv */
// Controller: sequences list scans, shifts, drops, appends and the final update.
module lrk_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  lrk_pkg::sts_t sts,
	output lrk_pkg::ctl_t ctl,
	output logic          pick_mode,
	output logic          busy,
	output logic          done,
	output logic [1:0]    status
);
	import lrk_pkg::*;

	typedef enum logic [10:0] {
		S_IDLE  = 11'b00000000001,
		S_DEC   = 11'b00000000010,
		S_RD    = 11'b00000000100,
		S_CHK   = 11'b00000001000,
		S_MCHK  = 11'b00000010000,
		S_SHRD  = 11'b00000100000,
		S_SHWR  = 11'b00001000000,
		S_DROP  = 11'b00010000000,
		S_APP   = 11'b00100000000,
		S_APPLY = 11'b01000000000,
		S_DONE  = 11'b10000000000
	} state_t;

	// phase of the operation: which scan is running
	typedef enum logic [2:0] {
		P_FIND_OLD, P_FIND_YOUNG, P_PICK_YOUNG, P_PICK_OLD, P_FORGET_OLD
	} phase_t;

	state_t     state_q, state_d;
	phase_t     ph_q, ph_d;
	logic       sel_q, sel_d;
	logic       app_q, app_d;   // append after drop
	logic       appold_q, appold_d;
	logic [1:0] st_q, st_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			ph_q     <= P_FIND_OLD;
			sel_q    <= 1'b0;
			app_q    <= 1'b0;
			appold_q <= 1'b0;
			st_q     <= ST_OK;
		end else begin
			state_q  <= state_d;
			ph_q     <= ph_d;
			sel_q    <= sel_d;
			app_q    <= app_d;
			appold_q <= appold_d;
			st_q     <= st_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		ph_d     = ph_q;
		sel_d    = sel_q;
		app_d    = app_q;
		appold_d = appold_q;
		st_d     = st_q;
		ctl      = '{cmd: CMD_NONE, sel_old: sel_q, idx_clr: 1'b0};
		case (state_q)
			S_IDLE: if (start) begin
				ctl.cmd  = CMD_LOAD;
				state_d  = S_DEC;
			end
			S_DEC: begin
				ctl.idx_clr = 1'b1;
				st_d  = ST_OK;
				app_d = 1'b0;
				state_d = S_RD;
				if (sts.kind == KIND_EVICT) begin
					ph_d = P_PICK_YOUNG; sel_d = 1'b0;
					if (!sts.any_evict) begin st_d = ST_EMPTY; state_d = S_DONE; end
				end else if (sts.invalid) begin
					st_d = ST_INVALID; state_d = S_DONE;
				end else if (sts.kind == KIND_MARK) begin
					state_d = S_APPLY;
				end else if (sts.kind == KIND_REMOVE) begin
					if (!sts.tracked) state_d = S_DONE;
					else if (!sts.marked) begin st_d = ST_PINNED; state_d = S_DONE; end
					else begin ph_d = P_FIND_YOUNG; sel_d = 1'b0; end
				end else begin
					ph_d = P_FIND_OLD; sel_d = 1'b1;
				end
			end
			S_RD: begin
				if (sts.at_end) begin
					ctl.idx_clr = 1'b1;
					case (ph_q)
						P_FIND_OLD: begin ph_d = P_FIND_YOUNG; sel_d = 1'b0; end
						P_FIND_YOUNG: begin
							if (sts.kind == KIND_ACCESS) begin
								app_d = 1'b1; appold_d = sts.k_is_one;
								sel_d = sts.k_is_one; state_d = S_APP;
							end else begin ph_d = P_FORGET_OLD; sel_d = 1'b1; end
						end
						P_PICK_YOUNG: begin ph_d = P_PICK_OLD; sel_d = 1'b1; end
						P_PICK_OLD: begin st_d = ST_EMPTY; state_d = S_DONE; end
						default: state_d = S_APPLY;
					endcase
				end else begin
					ctl.cmd = CMD_SCAN_RD;
					state_d = S_CHK;
				end
			end
			S_CHK: begin
				state_d = S_RD;
				if (pick_mode) begin
					// mark of the entry is read first, tested next cycle
					ctl.cmd = CMD_MARK_RD;
					state_d = S_MCHK;
				end else begin
					ctl.cmd = CMD_SCAN_CHK;
					if (sts.hit) begin
						state_d = S_SHRD;
						if (sts.kind == KIND_ACCESS) begin
							if (ph_q == P_FIND_OLD) begin app_d = 1'b1; appold_d = 1'b1; end
							else if (sts.tracked && sts.cnt_ge_k) begin
								app_d = 1'b1; appold_d = 1'b1;
							end else if (sts.tracked) state_d = S_APPLY;
							else begin
								app_d = 1'b1; appold_d = sts.k_is_one;
								state_d = S_DROP;
							end
						end
					end
				end
			end
			S_MCHK: begin
				ctl.cmd = CMD_MARK_CHK;
				state_d = S_RD;
				if (sts.hit) begin
					ph_d = P_FIND_YOUNG; sel_d = 1'b0;
					ctl.idx_clr = 1'b1;
				end
			end
			S_SHRD: begin
				if (sts.shift_end) state_d = S_DROP;
				else begin ctl.cmd = CMD_SHIFT_RD; state_d = S_SHWR; end
			end
			S_SHWR: begin
				ctl.cmd = CMD_SHIFT_WR;
				state_d = S_SHRD;
			end
			S_DROP: begin
				// untracked stale entry in young list: keep it, just append
				if (!(sts.kind == KIND_ACCESS && !sts.tracked)) ctl.cmd = CMD_DROP_END;
				ctl.idx_clr = 1'b1;
				if (app_q) begin sel_d = appold_q; state_d = S_APP; end
				else if (ph_q == P_FIND_YOUNG) begin ph_d = P_FORGET_OLD; sel_d = 1'b1; state_d = S_RD; end
				else state_d = S_APPLY;
			end
			S_APP: begin
				ctl.cmd = CMD_APPEND;
				state_d = S_APPLY;
			end
			S_APPLY: begin
				ctl.cmd = CMD_APPLY;
				state_d = S_DONE;
			end
			S_DONE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	assign pick_mode = (ph_q == P_PICK_YOUNG) || (ph_q == P_PICK_OLD);
	assign busy   = ((state_q != S_IDLE) && (state_q != S_DONE)) || sts.clearing;
	assign done   = (state_q == S_DONE);
	assign status = st_q;
endmodule

/* sv/lru_k_frame_replacer_core.sv */
// LRU-K frame replacer: top level with stream ports and register port.
// One item at a time: invalid ids and empty evicts end after decode, marks after decode and
// the update; list walks read each entry and then compare it (or, while an evict looks for
// a marked frame, read the entry, then its mark, then test the mark). The result waits in an
// output register; the next beat is taken at the edge after the result beat leaves.
// Async active-low reset empties both lists, sets frames_in_use 64 and history_depth 2, then a
// clearing pass zeroes all counts and marks before the first beat is taken.
module lru_k_frame_replacer_core #(
	parameter int MaxFrames  = lrk_pkg::MaxFramesDef,
	parameter int MaxHistory = lrk_pkg::MaxHistoryDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // kind[1:0], frame[9:2], make_evictable[10]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // status[1:0], evicted_frame[7:2], evictable_total[14:8]
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import lrk_pkg::*;

	localparam int AW = $clog2(MaxFrames);
	localparam int LW = $clog2(MaxFrames + 1);

	logic [6:0]  frames_q;
	logic [3:0]  hist_q;
	ctl_t        ctl;
	sts_t        sts;
	logic        pick_mode, busy, done, start;
	logic [1:0]  status;
	logic [AW-1:0] victim;
	logic [LW-1:0] ev_total;
	logic        out_v_q;
	logic [15:0] out_q;
	logic        wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_q <= 7'd64;
			hist_q   <= 4'd2;
		end else if (wr_en) begin
			if (paddr[2] == REG_HISTORY[0]) hist_q <= pwdata[3:0];
			else frames_q <= pwdata[6:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_HISTORY[0]) prdata[3:0] = hist_q;
		else prdata[6:0] = frames_q;
	end

	// item taken only while the controller sits idle, no clearing pass runs and no result waits
	assign s_tready = !busy && !done && !out_v_q;
	assign start    = s_tvalid && s_tready;

	lrk_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .sts(sts), .ctl(ctl),
		.pick_mode(pick_mode), .busy(busy), .done(done), .status(status));

	lrk_datapath #(.MaxFrames(MaxFrames), .MaxHistory(MaxHistory)) u_dp (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .pick_mode(pick_mode),
		.in_kind(s_tdata[1:0]), .in_frame(s_tdata[9:2]), .in_mk(s_tdata[10]),
		.frames_in_use(frames_q), .history_depth(hist_q),
		.sts(sts), .victim(victim), .ev_total(ev_total));

	// DONE lasts one cycle, then the controller returns to idle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_v_q <= 1'b0;
		else if (done) out_v_q <= 1'b1;
		else if (m_tready) out_v_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (done)
			out_q <= {1'b0, 7'(ev_total), (status == ST_OK) ? 6'(victim) : 6'd0, status};
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_q;

	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(ev_total) <= MaxFrames) else $error("evictable total overflow");
	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !s_tready) else $error("input taken while busy");
	a_done_out: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> m_tvalid) else $error("result lost");
endmodule
